### hdl/ncsc_pkg.sv
`default_nettype none

package ncsc_pkg;

  // Field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned CODE_W = 5;
  localparam int unsigned ERR_W  = 2;
  localparam int unsigned LVL_W  = 5;
  localparam int unsigned NUM_CODES = 1 << CODE_W;

  // Default stack depth, global entry included
  localparam int unsigned STACK_DEPTH_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ENTER = 2'd0,
    OP_EXIT  = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_TRANS = 2'd1,
    ERR_EXIT  = 2'd2,
    ERR_FULL  = 2'd3
  } err_e;

  localparam logic [CODE_W-1:0] CTX_GLOBAL     = 5'd0;
  localparam logic [CODE_W-1:0] CTX_ORIGIN_HTM = 5'd7;
  localparam logic [CODE_W-1:0] CTX_ORIGIN_STY = 5'd8;
  localparam logic [CODE_W-1:0] CTX_ORIGIN_JS  = 5'd9;

  // Bit t of row f set: code t may be entered from code f
  localparam logic [NUM_CODES-1:0] ALLOW_ROWS [NUM_CODES] = '{
    32'h0000_03FE,  // global -> element .. origin kinds
    32'h0080_1C02,  // element -> element, style, text, attribute, except
    32'h0001_C000,  // template definition -> template style/element/var
    32'h000E_0000,  // custom definition -> custom style/element/var
    32'h0000_0000,
    32'h0080_0000,  // namespace -> except
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'h0000_2000,  // style block -> selector style
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'h0010_0000,  // template style -> inherit
    32'h0000_0000, 32'h0000_0000,
    32'h0030_0000,  // custom style -> inherit, delete
    32'h0040_0000,  // custom element -> insert
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'h0000_0000
  };

  function automatic logic is_raw_origin(input logic [CODE_W-1:0] code);
    return (code == CTX_ORIGIN_HTM) || (code == CTX_ORIGIN_STY) ||
           (code == CTX_ORIGIN_JS);
  endfunction

  // Rule table hit, or self-nesting of a non-raw kind
  function automatic logic enter_ok(input logic [CODE_W-1:0] top,
                                    input logic [CODE_W-1:0] code);
    return ALLOW_ROWS[top][code] | ((code == top) & ~is_raw_origin(top));
  endfunction

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // register the input beat
    logic exec;      // apply the operation to the stack
    logic load;      // settle the top after a pop
    logic publish;   // load the result register
  } cmd_t;

endpackage

`default_nettype wire

### hdl/ncsc_in_if.sv
`default_nettype none

interface ncsc_in_if;
  logic                        valid;
  logic                        ready;
  logic [ncsc_pkg::OP_W-1:0]   opcode;
  logic [ncsc_pkg::CODE_W-1:0] context_code;

  modport source (output valid, output opcode, output context_code, input ready);
  modport sink   (input valid, input opcode, input context_code, output ready);
endinterface

`default_nettype wire

### hdl/ncsc_out_if.sv
`default_nettype none

interface ncsc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [ncsc_pkg::ERR_W-1:0]  error_kind;
  logic [ncsc_pkg::CODE_W-1:0] top_context;
  logic [ncsc_pkg::LVL_W-1:0]  stack_level;
  logic                        may_enter;
  logic                        found_in_stack;

  modport source (output valid, output accepted, output error_kind, output top_context,
                  output stack_level, output may_enter, output found_in_stack,
                  input ready);
  modport sink   (input valid, input accepted, input error_kind, input top_context,
                  input stack_level, input may_enter, input found_in_stack,
                  output ready);
endinterface

`default_nettype wire

### hdl/nesting_context_stack_checker_core.sv
`default_nettype none

// Nesting context stack checker. Each input beat carries an opcode (enter, exit,
// query, clear) and a context code; each one yields exactly one result beat with
// the outcome, the error kind, the top code and level after the operation, and
// whether the code may be entered from the new top and is present in the stack.
// An item passes through the accepting cycle, which captures it, stack update,
// top settle (a pop waits on the registered stack memory read), and result load.
// The next item is taken as soon as the result register holds the previous one,
// so a waiting result stalls input only if it is still unread when the following
// result is due; no new item is accepted before then. Presence is tracked by one
// occurrence counter per code, so there is no clearing pass; the stack memory is
// never read at an entry that was not written.
module nesting_context_stack_checker_core #(
  parameter int unsigned STACK_DEPTH = ncsc_pkg::STACK_DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ncsc_in_if.sink   in_i,
  ncsc_out_if.source out_o
);
  import ncsc_pkg::*;

  cmd_t cmd;

  ncsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  ncsc_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .opcode_i         (in_i.opcode),
    .context_code_i   (in_i.context_code),
    .accepted_o       (out_o.accepted),
    .error_kind_o     (out_o.error_kind),
    .top_context_o    (out_o.top_context),
    .stack_level_o    (out_o.stack_level),
    .may_enter_o      (out_o.may_enter),
    .found_in_stack_o (out_o.found_in_stack)
  );

endmodule

`default_nettype wire

### hdl/ncsc_ctrl.sv
`default_nettype none

module ncsc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ncsc_pkg::cmd_t     cmd_o
);
  import ncsc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   publish;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Result register may be refilled once empty or drained this cycle
  assign publish = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.exec    = (state_q == ST_EXEC);
    cmd_o.load    = (state_q == ST_LOAD);
    cmd_o.publish = publish;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_LOAD;
      ST_LOAD: state_d = ST_RESP;
      ST_RESP: if (publish) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### hdl/ncsc_dp.sv
`default_nettype none

module ncsc_dp #(
  parameter int unsigned STACK_DEPTH = ncsc_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ncsc_pkg::cmd_t              cmd_i,
  input  wire logic [ncsc_pkg::OP_W-1:0]   opcode_i,
  input  wire logic [ncsc_pkg::CODE_W-1:0] context_code_i,
  output logic                             accepted_o,
  output logic [ncsc_pkg::ERR_W-1:0]       error_kind_o,
  output logic [ncsc_pkg::CODE_W-1:0]      top_context_o,
  output logic [ncsc_pkg::LVL_W-1:0]       stack_level_o,
  output logic                             may_enter_o,
  output logic                             found_in_stack_o
);
  import ncsc_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  // Captured operation
  op_e                 op_q;
  logic [CODE_W-1:0]   code_q;

  // Stack state
  logic [CW-1:0]       count_q, count_d;
  logic [CODE_W-1:0]   top_q, top_d;
  logic [CODE_W-1:0]   stack_mem [STACK_DEPTH];
  logic [CODE_W-1:0]   rd_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       wr_idx, rd_idx;
  logic [CW-1:0]       below_top;

  // Occurrences of each code in the stack
  logic [CW-1:0]       occ_q [NUM_CODES];
  logic [CODE_W-1:0]   occ_addr;
  logic [CW-1:0]       occ_rd;
  logic                occ_we, occ_clr;
  logic [CW-1:0]       occ_wdata;

  logic                ok_q, ok_d;
  err_e                err_q, err_d;
  logic                allowed, full;
  logic [CW+LVL_W-1:0] level_ext;

  // Capture the input beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(opcode_i);
      code_q <= context_code_i;
    end
  end

  // One occurrence counter read per cycle: the old top on a pop, else the code
  assign occ_addr = (cmd_i.exec && op_q == OP_EXIT) ? top_q : code_q;
  assign occ_rd   = occ_q[occ_addr];

  assign allowed   = enter_ok(top_q, code_q);
  assign full      = (count_q >= CW'(STACK_DEPTH));
  assign below_top = count_q - CW'(2);
  assign wr_idx    = count_q[AW-1:0];
  assign rd_idx    = below_top[AW-1:0];

  // Operation decode
  always_comb begin
    ok_d      = ok_q;
    err_d     = err_q;
    count_d   = count_q;
    top_d     = top_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    occ_we    = 1'b0;
    occ_clr   = 1'b0;
    occ_wdata = occ_rd;
    if (cmd_i.exec) begin
      ok_d  = 1'b1;
      err_d = ERR_NONE;
      unique case (op_q)
        OP_ENTER: begin
          if (!allowed) begin
            ok_d  = 1'b0;
            err_d = ERR_TRANS;
          end else if (full) begin
            ok_d  = 1'b0;
            err_d = ERR_FULL;
          end else begin
            mem_we    = 1'b1;
            count_d   = count_q + CW'(1);
            top_d     = code_q;
            occ_we    = 1'b1;
            occ_wdata = occ_rd + CW'(1);
          end
        end
        OP_EXIT: begin
          if (count_q <= CW'(1)) begin
            ok_d  = 1'b0;
            err_d = ERR_EXIT;
          end else begin
            // Popping down to global alone needs no memory read
            mem_re    = (count_q > CW'(2));
            count_d   = count_q - CW'(1);
            occ_we    = 1'b1;
            occ_wdata = occ_rd - CW'(1);
          end
        end
        OP_CLEAR: begin
          count_d = CW'(1);
          top_d   = CTX_GLOBAL;
          occ_clr = 1'b1;
        end
        OP_QUERY: begin
        end
        default: begin
        end
      endcase
    end else if (cmd_i.load && op_q == OP_EXIT && ok_q) begin
      // The global entry sits at the bottom and is never read from memory
      top_d = (count_q == CW'(1)) ? CTX_GLOBAL : rd_q;
    end
  end

  // Stack memory, entries above the bottom only
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[wr_idx] <= code_q;
    end
    if (mem_re) begin
      rd_q <= stack_mem[rd_idx];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CW'(1);
      top_q   <= CTX_GLOBAL;
      ok_q    <= 1'b0;
      err_q   <= ERR_NONE;
    end else begin
      count_q <= count_d;
      top_q   <= top_d;
      ok_q    <= ok_d;
      err_q   <= err_d;
    end
  end

  // Occurrence counters; global counts once after reset and clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CODES; i++) begin
        occ_q[i] <= (i == 0) ? CW'(1) : '0;
      end
    end else if (occ_clr) begin
      for (int i = 0; i < NUM_CODES; i++) begin
        occ_q[i] <= (i == 0) ? CW'(1) : '0;
      end
    end else if (occ_we) begin
      occ_q[occ_addr] <= occ_wdata;
    end
  end

  assign level_ext = {{LVL_W{1'b0}}, count_q};

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      accepted_o       <= ok_q;
      error_kind_o     <= err_q;
      top_context_o    <= top_q;
      stack_level_o    <= level_ext[LVL_W-1:0];
      may_enter_o      <= allowed;
      found_in_stack_o <= (occ_rd != '0);
    end
  end

endmodule

`default_nettype wire
